FILE: rtl/lsb_stego_message_extractor_top_defines.svh
// ============================================================================
// LSB stego extractor assertion macros
// Shared concurrent assertion forms used by the extractor top level.
// ============================================================================
`ifndef LSB_STEGO_MESSAGE_EXTRACTOR_TOP_DEFINES_SVH
`define LSB_STEGO_MESSAGE_EXTRACTOR_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define LSE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge out of reset.
`define LSE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/lse_pkg.sv
// ============================================================================
// LSB stego extractor package
// Constants and types shared by the extractor modules.
// ============================================================================
package lse_pkg;

    // Stream geometry
    localparam int ByteBits    = 8;
    localparam int WindowBits  = 16;
    localparam int HoldBits    = WindowBits + ByteBits;
    localparam int CountW      = 5;
    localparam int ChunkBitsW  = 4;
    localparam int MaxResults  = 4;
    localparam int ResCountW   = 3;
    localparam int ResIdxW     = 2;
    localparam int PixelW      = 24;

    // End marker value after reset
    localparam logic [WindowBits-1:0] MarkerReset = 16'hFFFE;

    // One result chunk
    typedef struct packed {
        logic [ByteBits-1:0]   char_code;
        logic [ChunkBitsW-1:0] chunk_bits;
        logic                  end_of_message;
        logic                  marker_found;
    } chunk_t;

    // All chunks produced by one pixel
    typedef struct packed {
        chunk_t [MaxResults-1:0] chunk;
        logic [ResCountW-1:0]    count;
    } chunk_batch_t;

    // One registered pixel
    typedef struct packed {
        logic [ByteBits-1:0] red;
        logic [ByteBits-1:0] green;
        logic [ByteBits-1:0] blue;
        logic                last_pixel;
    } pixel_t;

endpackage

FILE: rtl/lse_extract.sv
// ============================================================================
// LSB stego bit extractor
// Holds the bit window and turns one pixel into up to four result chunks.
// ============================================================================
module lse_extract
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         step_en,
    input  lse_pkg::pixel_t              pixel,
    input  logic [lse_pkg::WindowBits-1:0] end_marker,
    output lse_pkg::chunk_batch_t        batch
);
    import lse_pkg::*;

    logic [HoldBits-1:0] held_bits_reg;
    logic [HoldBits-1:0] held_bits_next;
    logic [CountW-1:0]   held_count_reg;
    logic [CountW-1:0]   held_count_next;
    logic                done_reg;
    logic                done_next;

    // Walk the three channel bits, then flush on the last pixel.
    always_comb
    begin
        logic [HoldBits-1:0]  hb;
        logic [CountW-1:0]    hc;
        logic [CountW-1:0]    rem;
        logic [CountW-1:0]    shamt;
        logic [2:0]           k;
        logic                 dn;
        logic [2:0]           bits;
        logic [ResCountW-1:0] n;
        chunk_t               res [MaxResults];

        hb    = held_bits_reg;
        hc    = held_count_reg;
        dn    = done_reg;
        bits  = {pixel.blue[0], pixel.green[0], pixel.red[0]};
        n     = '0;
        rem   = '0;
        shamt = '0;
        k     = '0;
        for (int r = 0; r < MaxResults; r++)
        begin
            res[r] = '0;
        end

        // Append bits; emit proven bytes and watch for the marker.
        for (int i = 0; i < 3; i++)
        begin
            if (!dn)
            begin
                hb = {hb[HoldBits-2:0], bits[i]};
                hc = hc + CountW'(1);
                if (hc >= CountW'(HoldBits))
                begin
                    res[n[ResIdxW-1:0]] = '{char_code: hb[HoldBits-1:WindowBits],
                                            chunk_bits: ChunkBitsW'(ByteBits),
                                            end_of_message: 1'b0,
                                            marker_found: 1'b0};
                    n  = n + ResCountW'(1);
                    hc = CountW'(WindowBits);
                end
                if (hc >= CountW'(WindowBits) && hb[WindowBits-1:0] == end_marker)
                begin
                    k = 3'(hc - CountW'(WindowBits));
                    res[n[ResIdxW-1:0]] = '{
                        char_code: hb[HoldBits-1:WindowBits] &
                                   ByteBits'((9'd1 << k) - 9'd1),
                        chunk_bits: ChunkBitsW'(k),
                        end_of_message: 1'b1,
                        marker_found: 1'b1};
                    n  = n + ResCountW'(1);
                    dn = 1'b1;
                end
            end
        end

        // Image end without a marker: flush everything still held.
        if (pixel.last_pixel && !dn)
        begin
            if (hc == '0)
            begin
                res[n[ResIdxW-1:0]] = '{char_code: '0, chunk_bits: '0,
                                        end_of_message: 1'b1, marker_found: 1'b0};
                n = n + ResCountW'(1);
            end
            else
            begin
                rem = hc;
                for (int j = 0; j < 2; j++)
                begin
                    if (rem >= CountW'(ByteBits))
                    begin
                        shamt = rem - CountW'(ByteBits);
                        res[n[ResIdxW-1:0]] = '{
                            char_code: ByteBits'(hb >> shamt),
                            chunk_bits: ChunkBitsW'(ByteBits),
                            end_of_message: (rem == CountW'(ByteBits)),
                            marker_found: 1'b0};
                        n   = n + ResCountW'(1);
                        rem = rem - CountW'(ByteBits);
                    end
                end
                if (rem != '0)
                begin
                    res[n[ResIdxW-1:0]] = '{
                        char_code: ByteBits'(hb) & ByteBits'((9'd1 << rem[2:0]) - 9'd1),
                        chunk_bits: ChunkBitsW'(rem),
                        end_of_message: 1'b1,
                        marker_found: 1'b0};
                    n = n + ResCountW'(1);
                end
            end
        end

        // The state clears after the last pixel of an image.
        if (pixel.last_pixel)
        begin
            held_bits_next  = '0;
            held_count_next = '0;
            done_next       = 1'b0;
        end
        else
        begin
            held_bits_next  = hb;
            held_count_next = hc;
            done_next       = dn;
        end

        for (int r = 0; r < MaxResults; r++)
        begin
            batch.chunk[r] = res[r];
        end
        batch.count = n;
    end

    // Window state advances once per processed pixel.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_bits_reg  <= '0;
            held_count_reg <= '0;
            done_reg       <= 1'b0;
        end
        else if (step_en)
        begin
            held_bits_reg  <= held_bits_next;
            held_count_reg <= held_count_next;
            done_reg       <= done_next;
        end
    end

endmodule

FILE: rtl/lse_chunk_queue.sv
// ============================================================================
// LSB stego result chunk queue
// Buffers one pixel's chunks and drains them into a registered output.
// ============================================================================
module lse_chunk_queue
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  lse_pkg::chunk_batch_t batch,
    output logic                  bank_free,
    input  logic                  out_ready,
    output logic                  out_valid,
    output lse_pkg::chunk_t       out_chunk
);
    import lse_pkg::*;

    chunk_t               bank_reg [MaxResults];
    logic [ResCountW-1:0] left_reg;
    logic [ResCountW-1:0] left_next;
    logic [ResIdxW-1:0]   rd_reg;
    logic [ResIdxW-1:0]   rd_next;
    logic                 out_valid_reg;
    chunk_t               out_chunk_reg;
    logic                 out_free;
    logic                 pop;

    // Output register takes a new chunk when empty or being taken.
    assign out_free  = !out_valid_reg || out_ready;
    assign pop       = (left_reg != '0) && out_free;
    assign bank_free = (left_reg == '0) || (left_reg == ResCountW'(1) && pop);

    // Read pointer and remaining count of the bank.
    always_comb
    begin
        left_next = left_reg;
        rd_next   = rd_reg;
        if (load)
        begin
            left_next = batch.count;
            rd_next   = '0;
        end
        else if (pop)
        begin
            left_next = left_reg - ResCountW'(1);
            rd_next   = rd_reg + ResIdxW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg      <= '0;
            rd_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            left_reg <= left_next;
            rd_reg   <= rd_next;
            if (out_free)
            begin
                out_valid_reg <= pop;
            end
        end
    end

    // Payload storage; no reset needed.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int r = 0; r < MaxResults; r++)
            begin
                bank_reg[r] <= batch.chunk[r];
            end
        end
        if (pop)
        begin
            out_chunk_reg <= bank_reg[rd_reg];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_chunk = out_chunk_reg;

endmodule

FILE: rtl/lsb_stego_message_extractor_top.sv
// ============================================================================
// LSB stego message extractor
// Pulls a hidden message out of pixel LSBs and stops at a 16-bit end marker.
//
//   Channel  Direction  Transfer contents
//   s_axis   in         one pixel: red, green, blue; tlast = last_pixel
//   m_axis   out        one chunk: char_code, chunk_bits; tlast = end_of_message,
//                       tuser = marker_found
//   cfg      in         end marker write, taken on any rising clock edge with cfg_wr_en high
//
// A pixel passes the input register, chunk bank and output register before its
// first chunk appears. Pixels flow at one per cycle while each yields at most
// one chunk and the output is not stalled; a pixel with more chunks (at most
// four) holds the single output port until all have gone out. Reset clears
// the bit window and sets the end marker to 0xFFFE. A stalled output backs up
// through the chunk bank into the input register without losing transfers.
// ============================================================================
`include "lsb_stego_message_extractor_top_defines.svh"

module lsb_stego_message_extractor_top
(
    input  logic        clk,
    input  logic        rst_n,
    // Pixel input; tdata: red[7:0], green[15:8], blue[23:16]
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,
    input  logic        s_axis_tlast,
    // Chunk output; tdata: char_code[7:0], chunk_bits[11:8], zero[15:12]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,
    output logic        m_axis_tlast,
    // tuser: marker_found[0]
    output logic        m_axis_tuser,
    // End marker register
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data
);
    import lse_pkg::*;

    logic [WindowBits-1:0] end_marker_reg;
    logic                  in_valid_reg;
    pixel_t                pixel_reg;
    logic                  step;
    logic                  bank_free;
    chunk_batch_t          batch;
    chunk_t                out_chunk;

    // End marker register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            end_marker_reg <= MarkerReset;
        end
        else if (cfg_wr_en)
        begin
            end_marker_reg <= cfg_wr_data;
        end
    end

    // Input register: refilled whenever its pixel moves on.
    assign step          = in_valid_reg && bank_free;
    assign s_axis_tready = !in_valid_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            pixel_reg <= '{red: s_axis_tdata[7:0], green: s_axis_tdata[15:8],
                           blue: s_axis_tdata[23:16], last_pixel: s_axis_tlast};
        end
    end

    lse_extract u_extract
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_en    (step),
        .pixel      (pixel_reg),
        .end_marker (end_marker_reg),
        .batch      (batch)
    );

    lse_chunk_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (step),
        .batch     (batch),
        .bank_free (bank_free),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_chunk (out_chunk)
    );

    // Output packing.
    assign m_axis_tdata = {4'b0000, out_chunk.chunk_bits, out_chunk.char_code};
    assign m_axis_tlast = out_chunk.end_of_message;
    assign m_axis_tuser = out_chunk.marker_found;

    // Design checks.
    `LSE_ASSERT_NOW(a_found_is_last, m_axis_tvalid && m_axis_tuser, m_axis_tlast,
                    "marker chunk not flagged end of message")
    `LSE_ASSERT_NOW(a_mid_full_byte, m_axis_tvalid && !m_axis_tlast,
                    m_axis_tdata[11:8] == 4'd8, "chunk inside message is not a full byte")
    `LSE_ASSERT_NOW(a_batch_bound, step, batch.count <= 3'd4,
                    "pixel produced more than four chunks")
    `LSE_ASSERT_NEXT(a_out_held, m_axis_tvalid && !m_axis_tready,
                     m_axis_tvalid && $stable(m_axis_tdata), "output changed while stalled")

endmodule

FILE: dv/tb_lsb_stego_message_extractor_top.sv
`timescale 1ns / 100ps
// ============================================================================
// LSB stego message extractor testbench
// Streams pixel images into the extractor and checks every chunk that comes
// out against a cycle-free prediction of the bit stream. Images carry hidden
// messages closed by the end marker, broken markers, or plain noise, under
// several marker settings, random idling on both streams and one long
// output hold-off.
// ============================================================================
module tb_lsb_stego_message_extractor_top;

    import lse_pkg::*;

    localparam int CycleLimit   = 200000;
    localparam int SettleCycles = 8;

    // Clock, reset and block ports
    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        m_axis_tuser;
    logic        cfg_wr_en     = 1'b0;
    logic [15:0] cfg_wr_data   = '0;

    // Predicted extractor state
    logic [23:0] bit_window   = '0;
    int          bits_held    = 0;
    bit          msg_ended    = 1'b0;
    logic [15:0] marker_value = MarkerReset;

    // Chunks predicted but not yet transferred
    chunk_t      pending_chunks[$];

    // Stimulus control and bookkeeping
    bit          image_bits[$];
    bit          src_idle_en     = 1'b1;
    bit          snk_idle_en     = 1'b1;
    int          hold_left       = 0;
    int          sink_stall_left = 0;
    int          items_sent      = 0;
    int          chunks_seen     = 0;
    int          error_count     = 0;
    int          cycle_count     = 0;

    lsb_stego_message_extractor_top u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    // 100 MHz clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run limit in case the block hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit)
        begin
            $display("FAIL lsb_stego_message_extractor_top");
            $finish;
        end
    end

    // Output ready: a long hold-off when requested, else random stall bursts.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (sink_stall_left > 0)
        begin
            sink_stall_left = sink_stall_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (snk_idle_en && $urandom_range(0, 4) == 0)
        begin
            sink_stall_left = $urandom_range(0, 7);
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic flag_error(input string msg);
        error_count++;
        $display("ERROR @%0t: %s", $time, msg);
    endtask

    // Compare each output transfer with the oldest predicted chunk.
    always @(posedge clk)
    begin
        chunk_t want;
        if (rst_n && m_axis_tvalid === 1'b1 && m_axis_tready)
        begin
            if (pending_chunks.size() == 0)
            begin
                flag_error($sformatf("unexpected chunk tdata=%04h last=%b user=%b",
                                     m_axis_tdata, m_axis_tlast, m_axis_tuser));
            end
            else
            begin
                want = pending_chunks.pop_front();
                if (m_axis_tdata[7:0] !== want.char_code)
                    flag_error($sformatf("chunk %0d char_code %02h, expected %02h",
                                         chunks_seen, m_axis_tdata[7:0], want.char_code));
                if (m_axis_tdata[11:8] !== want.chunk_bits)
                    flag_error($sformatf("chunk %0d chunk_bits %0d, expected %0d",
                                         chunks_seen, m_axis_tdata[11:8], want.chunk_bits));
                if (m_axis_tdata[15:12] !== 4'b0000)
                    flag_error($sformatf("chunk %0d pad bits %h, expected 0",
                                         chunks_seen, m_axis_tdata[15:12]));
                if (m_axis_tlast !== want.end_of_message)
                    flag_error($sformatf("chunk %0d end_of_message %b, expected %b",
                                         chunks_seen, m_axis_tlast, want.end_of_message));
                if (m_axis_tuser !== want.marker_found)
                    flag_error($sformatf("chunk %0d marker_found %b, expected %b",
                                         chunks_seen, m_axis_tuser, want.marker_found));
            end
            chunks_seen++;
        end
    end

    function automatic void push_chunk(input logic [7:0] code, input logic [3:0] nbits,
                                       input logic eom, input logic found);
        chunk_t c;
        c.char_code      = code;
        c.chunk_bits     = nbits;
        c.end_of_message = eom;
        c.marker_found   = found;
        pending_chunks.push_back(c);
    endfunction

    // Work out the chunks that one accepted pixel causes.
    function automatic void predict_pixel(input logic [23:0] data, input logic is_last);
        logic [2:0] lsbs;
        int         i;
        int         k;
        int         rem;
        lsbs = {data[0], data[8], data[16]};
        if (!msg_ended)
        begin
            for (i = 0; i < 3; i++)
            begin
                bit_window = {bit_window[22:0], lsbs[2 - i]};
                bits_held++;
                // A byte is safe once sixteen newer bits sit behind it.
                if (bits_held >= WindowBits + ByteBits)
                begin
                    push_chunk(bit_window[23:16], 4'(ByteBits), 1'b0, 1'b0);
                    bits_held = WindowBits;
                end
                if (bits_held >= WindowBits && bit_window[15:0] == marker_value)
                begin
                    k = bits_held - WindowBits;
                    push_chunk(8'(bit_window[23:16] & ((1 << k) - 1)), 4'(k), 1'b1, 1'b1);
                    msg_ended = 1'b1;
                    break;
                end
            end
        end
        // End of image: flush what is held unless the marker already closed it.
        if (is_last)
        begin
            if (!msg_ended)
            begin
                rem = bits_held;
                if (rem == 0)
                begin
                    push_chunk(8'h00, 4'd0, 1'b1, 1'b0);
                end
                else
                begin
                    while (rem >= ByteBits)
                    begin
                        push_chunk(8'(bit_window >> (rem - ByteBits)), 4'(ByteBits),
                                   rem == ByteBits, 1'b0);
                        rem -= ByteBits;
                    end
                    if (rem > 0)
                        push_chunk(8'(bit_window & ((24'd1 << rem) - 1)), 4'(rem),
                                   1'b1, 1'b0);
                end
            end
            bit_window = '0;
            bits_held  = 0;
            msg_ended  = 1'b0;
        end
    endfunction

    // Offer one pixel, wait for its transfer, then predict its chunks.
    task automatic send_pixel(input logic [23:0] data, input logic is_last);
        if (src_idle_en && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tlast  <= is_last;
        @(posedge clk);
        while (s_axis_tready !== 1'b1) @(posedge clk);
        predict_pixel(data, is_last);
        items_sent++;
    endtask

    function automatic logic [7:0] rand_channel(input bit lsb);
        logic [7:0] v;
        v = 8'($urandom);
        v[0] = lsb;
        return v;
    endfunction

    // Pack image_bits three to a pixel, pad with random bits and trailing
    // pixels, and flag the final pixel as the end of the image.
    task automatic send_image(input int tail_pixels);
        int         npix;
        int         total;
        int         p;
        int         idx;
        bit         b[3];
        npix  = (image_bits.size() + 2) / 3;
        total = npix + tail_pixels;
        if (total == 0)
            total = 1;
        for (p = 0; p < total; p++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                idx  = p * 3 + c;
                b[c] = (idx < image_bits.size()) ? image_bits[idx] : 1'($urandom_range(0, 1));
            end
            send_pixel({rand_channel(b[2]), rand_channel(b[1]), rand_channel(b[0])},
                       p == total - 1);
        end
    endtask

    // Append the marker, MSB first, optionally with one bit inverted.
    function automatic void append_marker(input int flip_idx);
        for (int i = WindowBits - 1; i >= 0; i--)
            image_bits.push_back(marker_value[i] ^ (i == flip_idx));
    endfunction

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_chunks.size() != 0) @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
    endtask

    task automatic set_marker(input logic [15:0] value);
        wait_idle();
        cfg_wr_en    <= 1'b1;
        cfg_wr_data  <= value;
        marker_value = value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Mostly well-formed messages, some with a broken marker, some noise.
    task automatic send_random_image();
        int kind;
        int nbits;
        int tail;
        kind = $urandom_range(0, 9);
        image_bits.delete();
        if (kind < 7)
        begin
            nbits = $urandom_range(0, 6) * ByteBits + $urandom_range(0, 7);
            repeat (nbits) image_bits.push_back(1'($urandom_range(0, 1)));
            append_marker(kind == 6 ? int'($urandom_range(0, 15)) : -1);
            tail = $urandom_range(0, 3);
        end
        else
        begin
            repeat ($urandom_range(1, 45)) image_bits.push_back(1'($urandom_range(0, 1)));
            tail = 0;
        end
        send_image(tail);
    endtask

    task automatic run_images(input logic [15:0] marker, input int n_items,
                              input bit allow_idle);
        int goal;
        goal = items_sent + n_items;
        set_marker(marker);
        while (items_sent < goal)
        begin
            src_idle_en = allow_idle && ($urandom_range(0, 3) != 0);
            snk_idle_en = allow_idle && ($urandom_range(0, 3) != 0);
            send_random_image();
        end
    endtask

    // One-pixel images: partial chunk flush, upper channel bits ignored.
    task automatic test_single_pixels();
        send_pixel({8'hFF, 8'h00, 8'hFF}, 1'b1);
        send_pixel({8'h80, 8'h01, 8'hFE}, 1'b1);
        send_pixel({8'h00, 8'h00, 8'h00}, 1'b1);
        send_pixel({8'hFF, 8'hFF, 8'hFF}, 1'b1);
    endtask

    // Marker as the very first sixteen bits: empty closing chunk, then
    // ignored pixels and an image end that yields nothing.
    task automatic test_marker_at_start();
        image_bits.delete();
        append_marker(-1);
        send_image(2);
    endtask

    // One byte then the marker: the pending byte comes out before an empty
    // closing chunk, and the marker pixel also ends the image.
    task automatic test_byte_then_marker();
        image_bits.delete();
        repeat (ByteBits) image_bits.push_back(1'($urandom_range(0, 1)));
        append_marker(-1);
        send_image(0);
    endtask

    // Fifteen zero bits under an all-zero marker: too short to compare.
    task automatic test_short_stream();
        set_marker(16'h0000);
        image_bits.delete();
        repeat (15) image_bits.push_back(1'b0);
        send_image(0);
    endtask

    // Output held off for a long stretch while pixels keep coming.
    task automatic test_pressure();
        set_marker(16'($urandom));
        src_idle_en = 1'b0;
        snk_idle_en = 1'b0;
        @(negedge clk);
        hold_left = 150;
        @(posedge clk);
        image_bits.delete();
        repeat (120) image_bits.push_back(1'($urandom_range(0, 1)));
        send_image(0);
        src_idle_en = 1'b1;
        snk_idle_en = 1'b1;
    endtask

    task automatic test_random_images();
        run_images(16'hFFFF, 62, 1'b1);
        run_images(16'h0000, 62, 1'b1);
        run_images(16'($urandom), 62, 1'b1);
        run_images(16'h8001, 62, 1'b1);
        run_images(16'($urandom), 62, 1'b1);
    endtask

    // Final stretch at full rate on both sides.
    task automatic test_full_rate();
        run_images(MarkerReset, 50, 1'b0);
    endtask

    // Test sequence and verdict.
    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        test_single_pixels();
        test_marker_at_start();
        test_byte_then_marker();
        test_short_stream();
        test_pressure();
        test_random_images();
        test_full_rate();
        wait_idle();
        if (error_count == 0)
            $display("PASS lsb_stego_message_extractor_top");
        else
            $display("FAIL lsb_stego_message_extractor_top");
        $finish;
    end

endmodule
